// ===== sv/lsw_pkg.sv =====
// Shared types and constants for the link silence watchdog.
// No dependencies; every other file imports this package.
package lsw_pkg;

  localparam int SECS_W        = 16;  // configured time in seconds
  localparam int CNT_W         = 14;  // tick counters
  localparam int SPT_DEFAULT   = 5;   // seconds per tick
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int SETTLE_W      = 2;

  localparam logic [CNT_W-1:0]    CNT_MAX          = {CNT_W{1'b1}};
  localparam logic [SECS_W-1:0]   INACTIVE_RST     = SECS_W'(30);
  localparam logic [SECS_W-1:0]   SILENT_RST       = SECS_W'(30);
  localparam logic [SECS_W-1:0]   EXIT_RST         = SECS_W'(0);
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES    = SETTLE_W'(2);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INACTIVE = 2'd0,
    CFG_SILENT   = 2'd1,
    CFG_EXIT     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_SHUTDOWN = 1'b1
  } op_t;

  // Thresholds in ticks, handed from the threshold unit to the core
  typedef struct packed {
    logic              settled;   // thresholds match the current registers
    logic              exit_en;   // silent exit time is nonzero
    logic [SECS_W-1:0] inact;
    logic [SECS_W-1:0] silent;
    logic [SECS_W-1:0] warn;
    logic [SECS_W-1:0] exit_thr;
  } thr_t;

endpackage

// ===== sv/link_silence_watchdog_unit.sv =====
// Top level of the link silence watchdog: threshold unit plus counter core.
// Depends on lsw_pkg, lsw_thresh and lsw_core.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata: activity, remote rx, remote open
//          |     |                       | tuser: op (tick or shutdown)
//  out_    | out | out_tvalid/out_tready | tdata: warn, exit, reconnect, halted
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (seconds)
//
// One request per cycle unless a stalled result or a threshold refresh holds
// the input: the counter update is a single combinational pass from the accepted
// request into the result register, and exactly one result follows it on the next cycle.
// The result register decouples the sides: a new request is taken while the
// last result waits, as long as out_tready drains it in the same cycle.
// A configuration write, and reset, close the input while the reciprocal
// multiply (register, then quotient and clamp) refreshes thresholds.
// Reset is synchronous and active low; configuration returns to its defaults.
module link_silence_watchdog_unit
  import lsw_pkg::*;
#(
  parameter int SECONDS_PER_TICK = SPT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] local activity seen, [1] remote rx seen,
                                             // [2] remote_open, rest zero
  input  logic                   in_tuser,   // [0] op
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] warn_pulse, [1] exit_pulse,
                                             // [2] reconnect_pulse, [3] halted, rest zero
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]      cfg_data
);

  thr_t thr;

  // Seconds-to-ticks conversion; also tells the core when thresholds are fresh
  lsw_thresh #(
    .SECONDS_PER_TICK(SECONDS_PER_TICK)
  ) u_thresh (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // Counters, halt latch and the result register
  lsw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .thr        (thr),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/lsw_thresh.sv =====
// Configuration registers and seconds-to-ticks conversion for the watchdog.
// Depends on lsw_pkg. Division by the tick length is a reciprocal multiply.
module lsw_thresh
  import lsw_pkg::*;
#(
  parameter int SECONDS_PER_TICK = SPT_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]      cfg_data,
  output thr_t                   thr
);

  // floor(v / D) == (v * RECIP) >> SHIFT for every SECS_W-bit v
  localparam int SHIFT  = SECS_W + $clog2(SECONDS_PER_TICK);
  localparam int RECIP_W = SECS_W + 1;
  localparam int PROD_W  = SECS_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + longint'(SECONDS_PER_TICK) - 64'd1) / longint'(SECONDS_PER_TICK);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [SECS_W-1:0]   inact_secs_r, sil_secs_r, exit_secs_r;
  logic [PROD_W-1:0]   inact_prod_r, silent_prod_r, exit_prod_r;
  logic [SECS_W-1:0]   inact_thr_r, silent_thr_r, warn_thr_r, exit_thr_r;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic [SECS_W-1:0]   inact_q, silent_q, exit_q, silent_cl, warn_q;
  logic                wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inact_secs_r <= INACTIVE_RST;
      sil_secs_r   <= SILENT_RST;
      exit_secs_r  <= EXIT_RST;
    end else if (wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INACTIVE: inact_secs_r <= cfg_data;
        CFG_SILENT:   sil_secs_r   <= cfg_data;
        CFG_EXIT:     exit_secs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: reciprocal products
  always_ff @(posedge clk) begin
    inact_prod_r  <= PROD_W'(inact_secs_r) * PROD_W'(RECIP);
    silent_prod_r <= PROD_W'(sil_secs_r)   * PROD_W'(RECIP);
    exit_prod_r   <= PROD_W'(exit_secs_r)  * PROD_W'(RECIP);
  end

  // Stage 2: quotient, clamp to at least one tick, warn at half
  always_comb begin
    inact_q   = SECS_W'(inact_prod_r >> SHIFT);
    silent_q  = SECS_W'(silent_prod_r >> SHIFT);
    exit_q    = SECS_W'(exit_prod_r >> SHIFT);
    silent_cl = (silent_q == '0) ? SECS_W'(1) : silent_q;
    warn_q    = ((silent_cl >> 1) == '0) ? SECS_W'(1) : (silent_cl >> 1);
  end

  always_ff @(posedge clk) begin
    inact_thr_r  <= (inact_q == '0) ? SECS_W'(1) : inact_q;
    silent_thr_r <= silent_cl;
    warn_thr_r   <= warn_q;
    exit_thr_r   <= (exit_q == '0) ? SECS_W'(1) : exit_q;
  end

  // Hold off items until a new register value has reached the thresholds
  always_comb begin
    if (wr)
      settle_nxt = SETTLE_CYCLES;
    else if (settle_r != '0)
      settle_nxt = settle_r - SETTLE_W'(1);
    else
      settle_nxt = settle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= SETTLE_CYCLES;
    else        settle_r <= settle_nxt;
  end

  always_comb begin
    thr.settled  = (settle_r == '0);
    thr.exit_en  = (exit_secs_r != '0);
    thr.inact    = inact_thr_r;
    thr.silent   = silent_thr_r;
    thr.warn     = warn_thr_r;
    thr.exit_thr = exit_thr_r;
  end

endmodule

// ===== sv/lsw_core.sv =====
// Watchdog counters, per-item update and the result register.
// Depends on lsw_pkg; thresholds come from lsw_thresh.
module lsw_core
  import lsw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  thr_t                   thr,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CNT_W-1:0] inact_r, inact_nxt;
  logic [CNT_W-1:0] silent_r, silent_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             warned_r, warned_nxt;
  logic             halted_r, halted_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       res_r, res_nxt;
  logic             take;
  logic             act, rx, open_link;
  logic             warn, ext, rec;
  logic [CNT_W-1:0] inc_inact, inc_silent, inc_total;

  assign act       = in_tdata[0];
  assign rx        = in_tdata[1];
  assign open_link = in_tdata[2];

  assign in_tready = thr.settled & (~out_valid_r | out_tready);
  assign take      = in_tvalid & in_tready;

  assign inc_inact  = (inact_r  == CNT_MAX) ? inact_r  : inact_r  + CNT_W'(1);
  assign inc_silent = (silent_r == CNT_MAX) ? silent_r : silent_r + CNT_W'(1);
  assign inc_total  = (total_r  == CNT_MAX) ? total_r  : total_r  + CNT_W'(1);

  always_comb begin
    inact_nxt  = inact_r;
    silent_nxt = silent_r;
    total_nxt  = total_r;
    warned_nxt = warned_r;
    halted_nxt = halted_r;
    warn       = 1'b0;
    ext        = 1'b0;
    rec        = 1'b0;
    if (!halted_r) begin
      if (op_t'(in_tuser) == OP_SHUTDOWN) begin
        halted_nxt = 1'b1;
      end else if (!act) begin
        silent_nxt = '0;
        total_nxt  = '0;
        warned_nxt = 1'b0;
        inact_nxt  = inc_inact;
        if (SECS_W'(inc_inact) >= thr.inact) begin
          rec       = open_link;
          inact_nxt = '0;
        end
      end else if (rx) begin
        inact_nxt  = '0;
        silent_nxt = '0;
        total_nxt  = '0;
        warned_nxt = 1'b0;
      end else begin
        inact_nxt  = '0;
        silent_nxt = inc_silent;
        total_nxt  = inc_total;
        if (!warned_r && SECS_W'(inc_total) >= thr.warn) begin
          warn       = 1'b1;
          warned_nxt = 1'b1;
        end
        if (thr.exit_en && SECS_W'(inc_total) >= thr.exit_thr) begin
          ext        = 1'b1;
          halted_nxt = 1'b1;
        end else if (SECS_W'(inc_silent) >= thr.silent) begin
          rec        = open_link;
          silent_nxt = '0;
        end
      end
    end
    res_nxt       = {halted_nxt, rec, ext, warn};
    out_valid_nxt = take | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inact_r     <= '0;
      silent_r    <= '0;
      total_r     <= '0;
      warned_r    <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        inact_r  <= inact_nxt;
        silent_r <= silent_nxt;
        total_r  <= total_nxt;
        warned_r <= warned_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-4){1'b0}}, res_r};

endmodule

// ===== sv/lsw_checker.sv =====
// Port-level checks for the link silence watchdog, bound to the top level.
// Depends on lsw_pkg and link_silence_watchdog_unit.
module lsw_checker
  import lsw_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  logic halt_seen_r;

  // Remember a delivered halted result; only reset leaves the halt
  always_ff @(posedge clk) begin
    if (!rst_n)
      halt_seen_r <= 1'b0;
    else if (out_tvalid && out_tready && out_tdata[3])
      halt_seen_r <= 1'b1;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request gave no result");

  a_exit_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[3] && !out_tdata[2])
    else $error("exit without halt or with reconnect");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && halt_seen_r |-> out_tdata[3:0] == 4'b1000)
    else $error("activity after halt");

  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_tready)
    else $error("input open before thresholds refreshed");

endmodule

bind link_silence_watchdog_unit lsw_checker u_lsw_checker (.*);
